### design/mvt_pkg.sv
// Package with shared types and constants of the version table.
package mvt_pkg;

  localparam int DefaultDepth = 64;

  typedef enum logic [2:0] {
    OP_CREATE   = 3'd0,
    OP_LOOKUP   = 3'd1,
    OP_MARK_DEL = 3'd2,
    OP_COMMIT   = 3'd3,
    OP_RB_CREATE = 3'd4,
    OP_RB_DROP  = 3'd5
  } op_t;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic CFG_TIME = 1'b0;
  localparam logic CFG_TX = 1'b1;

  typedef struct packed {
    logic [2:0]  operation;
    logic [15:0] key_id;
    logic [47:0] txn;
    logic [47:0] snapshot_time;
    logic [47:0] stamp_time;
    logic [47:0] init_del_txn;
    logic [47:0] init_del_time;
    logic [31:0] payload_in;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  slot;
    logic [31:0] payload_out;
  } rsp_t;

  typedef struct packed {
    logic [15:0] key;
    logic [31:0] payload;
    logic [47:0] create_txn;
    logic [47:0] create_time;
    logic [47:0] delete_txn;
    logic [47:0] delete_time;
    logic [31:0] order;
  } rec_t;

endpackage

### design/mvcc_version_table_top.sv
// Top level of the version table: sequencer, record memory and result register.
// An operation is taken when start is high and busy is low, and the next one can be taken
// once busy is low again. The sequencer visits each slot of the single record memory port in
// turn, first in a read state and then in an evaluate state, where a slot that changes is
// written back. A final mark state then writes the new or marked record and registers the
// result, which is strobed on done. Busy stays high through the strobe cycle. The result is
// shown for one cycle and cannot be stalled. Configuration writes are always taken.
module mvcc_version_table_top
  import mvt_pkg::*;
#(
  parameter int TABLE_DEPTH = DefaultDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  cmd_t        cmd,
  output logic        done,
  output rsp_t        rsp,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [47:0] cfg_data
);
  localparam int AW = $clog2(TABLE_DEPTH);

  typedef enum logic [2:0] {S_IDLE, S_READ, S_EVAL, S_MARK, S_DONE} state_t;

  state_t         state;
  cmd_t           cur;
  logic [47:0]    inv_time, inv_tx;
  logic [31:0]    order_counter;
  logic [TABLE_DEPTH-1:0] valid;
  logic [AW:0]    idx;
  logic [AW-1:0]  rd_slot;
  logic           found;
  logic [AW-1:0]  best;
  logic [31:0]    best_age;
  logic [31:0]    best_pay;
  rec_t           best_rec;
  logic           changed;

  logic           we;
  logic [AW-1:0]  addr;
  rec_t           wrec, rrec;
  logic           visible, key_hit, pend_cre, pend_del;
  logic [31:0]    age;
  logic           hit;
  rec_t           create_rec;
  rsp_t           rsp_next;

  assign cfg_ready = 1'b1;
  assign busy = state != S_IDLE;

  mvt_ram #(.Width($bits(rec_t)), .Depth(TABLE_DEPTH)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wrec), .rdata(rrec)
  );

  mvt_eval u_eval (
    .rec(rrec), .cmd(cur), .inv_time(inv_time),
    .visible(visible), .key_hit(key_hit), .pend_cre(pend_cre), .pend_del(pend_del)
  );

  always_comb begin
    create_rec.key = cur.key_id;
    create_rec.payload = cur.payload_in;
    create_rec.create_txn = cur.txn;
    create_rec.create_time = cur.stamp_time;
    create_rec.delete_txn = cur.init_del_txn;
    create_rec.delete_time = cur.init_del_time;
    create_rec.order = order_counter;
  end

  always_comb begin
    age = order_counter - rrec.order;
    hit = valid[rd_slot] && key_hit;
    we = 1'b0;
    wrec = rrec;
    addr = idx[AW-1:0];
    if (state == S_EVAL) begin
      addr = rd_slot;
      case (cur.operation)
        OP_COMMIT: begin
          if (hit && pend_cre) begin
            wrec.create_time = cur.stamp_time;
            we = 1'b1;
          end
          if (hit && pend_del && (cur.txn != inv_tx)) begin
            wrec.delete_time = cur.stamp_time;
            we = 1'b1;
          end
        end
        OP_RB_DROP: begin
          if (hit && pend_del) begin
            wrec.delete_txn = inv_tx;
            wrec.delete_time = inv_time;
            we = 1'b1;
          end
        end
        default: ;
      endcase
    end else if (state == S_MARK) begin
      addr = best;
      if (cur.operation == OP_CREATE && found) begin
        wrec = create_rec;
        we = 1'b1;
      end else if (cur.operation == OP_MARK_DEL && found) begin
        wrec = best_rec;
        wrec.delete_txn = cur.txn;
        wrec.delete_time = inv_time;
        we = 1'b1;
      end
    end else if (state == S_IDLE) begin
      addr = '0;
    end
  end

  always_comb begin
    rsp_next = '0;
    rsp_next.status = ST_NONE;
    case (cur.operation)
      OP_CREATE: begin
        if (found) begin
          rsp_next.status = ST_OK;
          rsp_next.slot = 6'(best);
        end else begin
          rsp_next.status = ST_FULL;
        end
      end
      OP_LOOKUP: begin
        if (found) begin
          rsp_next.status = ST_OK;
          rsp_next.slot = 6'(best);
          rsp_next.payload_out = best_pay;
        end
      end
      OP_MARK_DEL: begin
        if (found) begin
          rsp_next.status = ST_OK;
          rsp_next.slot = 6'(best);
        end
      end
      OP_COMMIT, OP_RB_CREATE, OP_RB_DROP: begin
        rsp_next.status = changed ? ST_OK : ST_NONE;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      inv_time <= '1;
      inv_tx <= '1;
      order_counter <= '0;
      valid <= '0;
      done <= 1'b0;
    end else begin
      done <= state == S_MARK;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_TIME) begin
          inv_time <= cfg_data;
        end else begin
          inv_tx <= cfg_data;
        end
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            cur <= cmd;
            idx <= '0;
            found <= 1'b0;
            changed <= 1'b0;
            best <= '0;
            best_age <= '0;
            best_pay <= '0;
            state <= S_READ;
          end
        end
        S_READ: begin
          rd_slot <= idx[AW-1:0];
          state <= S_EVAL;
        end
        S_EVAL: begin
          case (cur.operation)
            OP_CREATE: begin
              if (!valid[rd_slot] && !found) begin
                found <= 1'b1;
                best <= rd_slot;
              end
            end
            OP_LOOKUP, OP_MARK_DEL: begin
              if (hit && visible && (!found || age < best_age)) begin
                found <= 1'b1;
                best <= rd_slot;
                best_age <= age;
                best_pay <= rrec.payload;
                best_rec <= rrec;
              end
            end
            OP_COMMIT, OP_RB_DROP: begin
              if (we) changed <= 1'b1;
            end
            OP_RB_CREATE: begin
              if (hit && pend_cre) begin
                valid[rd_slot] <= 1'b0;
                changed <= 1'b1;
              end
            end
            default: ;
          endcase
          if (idx == (AW+1)'(TABLE_DEPTH - 1)) begin
            state <= S_MARK;
          end else begin
            idx <= idx + 1'b1;
            state <= S_READ;
          end
        end
        S_MARK: begin
          rsp <= rsp_next;
          if (cur.operation == OP_CREATE && found) begin
            valid[best] <= 1'b1;
            order_counter <= order_counter + 1'b1;
          end
          state <= S_DONE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) done |-> state == S_DONE)
    else $error("done outside final state");
  assert property (@(posedge clk) disable iff (rst) $rose(busy) |-> $past(start))
    else $error("busy rose without start");
  assert property (@(posedge clk) disable iff (rst)
    done && rsp.status == ST_FULL |-> $past(cur.operation) == OP_CREATE)
    else $error("full reported for non-create");
endmodule

### design/mvt_ram.sv
// Generic single-port RAM with registered read.
module mvt_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

### design/mvt_eval.sv
// Per-slot evaluation unit: visibility and pending create/delete checks.
module mvt_eval
  import mvt_pkg::*;
(
  input  rec_t        rec,
  input  cmd_t        cmd,
  input  logic [47:0] inv_time,
  output logic        visible,
  output logic        key_hit,
  output logic        pend_cre,
  output logic        pend_del
);
  logic cre_ok;

  always_comb begin
    key_hit = rec.key == cmd.key_id;
    cre_ok = (rec.create_txn == cmd.txn) ||
             ((rec.create_time != inv_time) && (rec.create_time < cmd.snapshot_time));
    visible = cre_ok && (rec.delete_txn != cmd.txn) &&
              ((rec.delete_time == inv_time) || (rec.delete_time >= cmd.snapshot_time));
    pend_cre = (rec.create_txn == cmd.txn) && (rec.create_time == inv_time);
    pend_del = (rec.delete_txn == cmd.txn) && (rec.delete_time == inv_time);
  end
endmodule

### bench/tb_mvcc_version_table_top.sv
// Self-checking testbench of the version table with its own predictor of the record table.
`timescale 1ns / 100ps

module tb_mvcc_version_table_top;
  import mvt_pkg::*;

  localparam int Depth = DefaultDepth;
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam logic [47:0] ALL_ONES48 = 48'hFFFF_FFFF_FFFF;
  localparam int QuietCycles = 6;

  typedef struct {
    bit          is_cfg;
    cmd_t        c;
    logic        idx;
    logic [47:0] val;
  } job_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  cmd_t        cmd = '0;
  logic        done;
  rsp_t        rsp;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_TIME;
  logic [47:0] cfg_data = '0;

  job_t job_q[$];
  rsp_t expected_rsp_q[$];
  bit   failed = 1'b0;

  // Predictor state.
  bit          m_valid[Depth];
  logic [15:0] m_key[Depth];
  logic [31:0] m_payload[Depth];
  logic [47:0] m_ctx[Depth];
  logic [47:0] m_ctime[Depth];
  logic [47:0] m_dtx[Depth];
  logic [47:0] m_dtime[Depth];
  logic [31:0] m_order[Depth];
  logic [31:0] m_counter = '0;
  logic [47:0] m_time_code = ALL_ONES48;
  logic [47:0] m_tx_code = ALL_ONES48;

  // Codes as the stimulus generator will see them when the phase runs.
  logic [47:0] gen_time_code = ALL_ONES48;
  logic [47:0] gen_tx_code = ALL_ONES48;

  mvcc_version_table_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .cmd      (cmd),
    .done     (done),
    .rsp      (rsp),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic bit visible_to(int s, logic [47:0] txn, logic [47:0] snap);
    if (m_ctx[s] != txn) begin
      if (m_ctime[s] == m_time_code) return 1'b0;
      if (m_ctime[s] >= snap) return 1'b0;
    end
    if (m_dtx[s] == txn) return 1'b0;
    if (m_dtime[s] == m_time_code) return 1'b1;
    return m_dtime[s] >= snap;
  endfunction

  function automatic int newest_visible_slot(cmd_t c);
    int best;
    logic [31:0] best_age;
    logic [31:0] age;
    best = -1;
    best_age = '0;
    for (int s = 0; s < Depth; s++) begin
      if (m_valid[s] && m_key[s] == c.key_id && visible_to(s, c.txn, c.snapshot_time)) begin
        age = m_counter - m_order[s];
        if (best < 0 || age < best_age) begin
          best = s;
          best_age = age;
        end
      end
    end
    return best;
  endfunction

  task automatic model_version_op(input cmd_t c);
    rsp_t r;
    int s;
    bit changed;
    bit cre;
    bit del;
    r = '0;
    r.status = ST_NONE;
    changed = 1'b0;
    case (c.operation)
      OP_CREATE: begin
        r.status = ST_FULL;
        for (int i = 0; i < Depth; i++) begin
          if (!m_valid[i] && r.status == ST_FULL) begin
            m_valid[i] = 1'b1;
            m_key[i] = c.key_id;
            m_payload[i] = c.payload_in;
            m_ctx[i] = c.txn;
            m_ctime[i] = c.stamp_time;
            m_dtx[i] = c.init_del_txn;
            m_dtime[i] = c.init_del_time;
            m_order[i] = m_counter;
            m_counter = m_counter + 32'd1;
            r.status = ST_OK;
            r.slot = i[5:0];
          end
        end
      end
      OP_LOOKUP, OP_MARK_DEL: begin
        s = newest_visible_slot(c);
        if (s >= 0) begin
          r.status = ST_OK;
          r.slot = s[5:0];
          if (c.operation == OP_LOOKUP) begin
            r.payload_out = m_payload[s];
          end else begin
            m_dtx[s] = c.txn;
            m_dtime[s] = m_time_code;
          end
        end
      end
      OP_COMMIT, OP_RB_CREATE, OP_RB_DROP: begin
        for (int i = 0; i < Depth; i++) begin
          if (m_valid[i] && m_key[i] == c.key_id) begin
            cre = m_ctx[i] == c.txn && m_ctime[i] == m_time_code;
            del = m_dtx[i] == c.txn && m_dtime[i] == m_time_code;
            if (c.operation == OP_COMMIT) begin
              if (cre) begin
                m_ctime[i] = c.stamp_time;
                changed = 1'b1;
              end
              if (c.txn != m_tx_code && del) begin
                m_dtime[i] = c.stamp_time;
                changed = 1'b1;
              end
            end else if (c.operation == OP_RB_CREATE) begin
              if (cre) begin
                m_valid[i] = 1'b0;
                changed = 1'b1;
              end
            end else if (del) begin
              m_dtx[i] = m_tx_code;
              m_dtime[i] = m_time_code;
              changed = 1'b1;
            end
          end
        end
        r.status = changed ? ST_OK : ST_NONE;
      end
      default: ;
    endcase
    expected_rsp_q.insert(expected_rsp_q.size(), r);
  endtask

  function automatic logic [47:0] rand48();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[47:0];
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 90);
  endfunction

  function automatic logic [47:0] pick_time();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return gen_time_code;
    if (r < 15) return rand48();
    if (r < 18) return ALL_ONES48;
    if (r < 20) return '0;
    return 48'($urandom_range(0, 200));
  endfunction

  function automatic logic [47:0] pick_txn();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return gen_tx_code;
    if (r < 12) return rand48();
    return 48'($urandom_range(1, 6));
  endfunction

  task automatic queue_cfg(input logic idx, input logic [47:0] val);
    job_t j;
    j.is_cfg = 1'b1;
    j.c = '0;
    j.idx = idx;
    j.val = val;
    job_q.insert(job_q.size(), j);
    if (idx == CFG_TIME) gen_time_code = val;
    else gen_tx_code = val;
  endtask

  task automatic queue_cmd(input logic [2:0] op, input logic [15:0] key,
                           input logic [47:0] txn, input logic [47:0] snap,
                           input logic [47:0] stamp, input logic [47:0] dtx,
                           input logic [47:0] dtime, input logic [31:0] pay);
    job_t j;
    j.is_cfg = 1'b0;
    j.idx = CFG_TIME;
    j.val = '0;
    j.c.operation = op;
    j.c.key_id = key;
    j.c.txn = txn;
    j.c.snapshot_time = snap;
    j.c.stamp_time = stamp;
    j.c.init_del_txn = dtx;
    j.c.init_del_time = dtime;
    j.c.payload_in = pay;
    job_q.insert(job_q.size(), j);
  endtask

  task automatic queue_random_phase(input int n);
    int r;
    logic [2:0] op;
    logic [15:0] key;
    logic [47:0] stamp;
    logic [47:0] dtx;
    logic [47:0] dtime;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 30) op = OP_CREATE;
      else if (r < 50) op = OP_LOOKUP;
      else if (r < 65) op = OP_MARK_DEL;
      else if (r < 72) op = OP_COMMIT;
      else if (r < 88) op = OP_RB_CREATE;
      else if (r < 97) op = OP_RB_DROP;
      else op = $urandom_range(0, 1) ? OP_SPARE_LO : OP_SPARE_HI;
      key = ($urandom_range(0, 99) < 90) ? 16'($urandom_range(0, 3)) : 16'($urandom);
      stamp = ($urandom_range(0, 99) < 88 && op == OP_CREATE) ? gen_time_code : pick_time();
      dtx = ($urandom_range(0, 99) < 70) ? gen_tx_code : pick_txn();
      dtime = ($urandom_range(0, 99) < 70) ? gen_time_code : pick_time();
      queue_cmd(op, key, pick_txn(), pick_time(), stamp, dtx, dtime, $urandom);
    end
  endtask

  // Driver: commands and register writes in queue order, writes only when the block is idle.
  int drv_gap = 0;
  int drv_quiet = 0;
  always @(posedge clk) begin
    bit   active;
    bit   nxt_start;
    bit   nxt_cfg;
    job_t j;
    if (rst) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      active = start || cfg_valid;
      if (start && !busy) begin
        model_version_op(cmd);
        active = 1'b0;
        drv_gap = pick_gap();
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_TIME) m_time_code = cfg_data;
        else m_tx_code = cfg_data;
        active = 1'b0;
        drv_gap = pick_gap();
      end
      if (!active) begin
        nxt_start = 1'b0;
        nxt_cfg = 1'b0;
        if (expected_rsp_q.size() == 0 && !busy) drv_quiet++;
        else drv_quiet = 0;
        if (drv_gap > 0) begin
          drv_gap--;
        end else if (job_q.size() > 0) begin
          j = job_q[0];
          if (!j.is_cfg) begin
            cmd <= j.c;
            nxt_start = 1'b1;
            void'(job_q.pop_front());
          end else if (drv_quiet >= QuietCycles) begin
            cfg_index <= j.idx;
            cfg_data <= j.val;
            nxt_cfg = 1'b1;
            void'(job_q.pop_front());
          end
        end
        start <= nxt_start;
        cfg_valid <= nxt_cfg;
      end
    end
  end

  // Monitor: every strobed result against the oldest expectation.
  always @(posedge clk) begin
    rsp_t e;
    if (!rst && done) begin
      if (expected_rsp_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got status %0d slot %0d payload %h",
                 $realtime, rsp.status, rsp.slot, rsp.payload_out);
        failed = 1'b1;
      end else begin
        e = expected_rsp_q.pop_front();
        if (rsp.status !== e.status || rsp.slot !== e.slot ||
            rsp.payload_out !== e.payload_out) begin
          $display("%0t: expected status %0d slot %0d payload %h, got status %0d slot %0d payload %h",
                   $realtime, e.status, e.slot, e.payload_out,
                   rsp.status, rsp.slot, rsp.payload_out);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    queue_cfg(CFG_TIME, ALL_ONES48);
    queue_cfg(CFG_TX, ALL_ONES48);
    queue_cmd(OP_LOOKUP, 16'hFFFF, 48'd5, 48'd9, '0, '0, '0, '0);
    queue_cmd(OP_CREATE, 16'hFFFF, 48'd5, '0, ALL_ONES48, ALL_ONES48, ALL_ONES48, 32'hFFFF_FFFF);
    queue_cmd(OP_LOOKUP, 16'hFFFF, 48'd5, 48'd1, '0, '0, '0, '0);
    queue_cmd(OP_LOOKUP, 16'hFFFF, 48'd6, 48'd1, '0, '0, '0, '0);
    queue_cmd(OP_COMMIT, 16'hFFFF, 48'd5, '0, 48'd10, '0, '0, '0);
    queue_cmd(OP_LOOKUP, 16'hFFFF, 48'd6, 48'd11, '0, '0, '0, '0);
    queue_cmd(OP_LOOKUP, 16'hFFFF, 48'd6, 48'd10, '0, '0, '0, '0);
    queue_cmd(OP_MARK_DEL, 16'hFFFF, 48'd6, 48'd11, '0, '0, '0, '0);
    queue_cmd(OP_LOOKUP, 16'hFFFF, 48'd6, 48'd11, '0, '0, '0, '0);
    queue_cmd(OP_RB_DROP, 16'hFFFF, 48'd6, '0, '0, '0, '0, '0);
    queue_cmd(OP_MARK_DEL, 16'hFFFF, 48'd6, 48'd11, '0, '0, '0, '0);
    queue_cmd(OP_COMMIT, 16'hFFFF, 48'd6, '0, 48'd20, '0, '0, '0);
    queue_cmd(OP_LOOKUP, 16'hFFFF, 48'd7, 48'd25, '0, '0, '0, '0);
    queue_cmd(OP_LOOKUP, 16'hFFFF, 48'd7, 48'd15, '0, '0, '0, '0);
    queue_cmd(OP_CREATE, 16'h0000, '0, '0, '0, ALL_ONES48, ALL_ONES48, '0);
    queue_cmd(OP_MARK_DEL, 16'h0000, ALL_ONES48, ALL_ONES48, '0, '0, '0, '0);
    queue_cmd(OP_COMMIT, 16'h0000, ALL_ONES48, '0, 48'd3, '0, '0, '0);
    queue_cmd(OP_CREATE, 16'h0001, 48'd7, '0, ALL_ONES48, 48'd2, 48'd4, 32'h5A5A_A5A5);
    queue_cmd(OP_RB_CREATE, 16'h0001, 48'd7, '0, '0, '0, '0, '0);
    queue_cmd(OP_RB_CREATE, 16'h0001, 48'd7, '0, '0, '0, '0, '0);
    queue_cmd(OP_SPARE_LO, 16'hFFFF, 48'd5, ALL_ONES48, '0, '0, '0, '0);
    queue_cmd(OP_SPARE_HI, 16'hFFFF, 48'd5, ALL_ONES48, '0, '0, '0, '0);
    // Fill the table past its depth with pending creates, then roll them all back.
    for (int k = 0; k < Depth; k++) begin
      queue_cmd(OP_CREATE, 16'h1234, 48'd9, '0, ALL_ONES48, ALL_ONES48, ALL_ONES48, $urandom);
    end
    queue_cmd(OP_RB_CREATE, 16'h1234, 48'd9, '0, '0, '0, '0, '0);
    queue_random_phase(420);
    queue_cfg(CFG_TIME, '0);
    queue_cfg(CFG_TX, '0);
    queue_random_phase(420);
    queue_cfg(CFG_TIME, 48'd100);
    queue_cfg(CFG_TX, 48'd3);
    queue_random_phase(420);
    queue_cfg(CFG_TIME, ALL_ONES48);
    queue_cfg(CFG_TX, ALL_ONES48);
    queue_random_phase(360);
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    wait (job_q.size() == 0);
    @(posedge clk);
    while (start || cfg_valid || expected_rsp_q.size() != 0) @(posedge clk);
    repeat (Depth + 20) @(posedge clk);
    if (!failed && expected_rsp_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #(12.0 * 1200000);
    $display("FAIL");
    $finish;
  end

endmodule
